// ===== src/lppg_pkg.sv =====
// shared types and constants for the line profile point generator
package lppg_pkg;

    localparam int DIM_W       = 11;
    localparam int IN_COORD_W  = 13;
    localparam int OUT_COORD_W = 10;
    localparam int INDEX_W     = 10;
    localparam int ADDR_W      = 20;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 56;
    localparam int REG_INDEX_W = 1;
    localparam int CMP_W       = IN_COORD_W + 1;

    localparam logic [REG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic
    {
        FUNC_LOAD = 1'b0,
        FUNC_NEXT = 1'b1
    } func_t;

    typedef struct packed
    {
        logic                   last;
        logic [ADDR_W-1:0]      pixel_address;
        logic [OUT_COORD_W-1:0] point_row;
        logic [OUT_COORD_W-1:0] point_col;
        logic [INDEX_W-1:0]     sample_index;
    } result_t;

endpackage

// ===== src/lppg_endpoint_prep.sv =====
// clamps both endpoints into the image and orders them for the walk
module lppg_endpoint_prep #(
    parameter int MAX_DIM = 1024
) (
    input  logic signed [lppg_pkg::IN_COORD_W-1:0] start_col,
    input  logic signed [lppg_pkg::IN_COORD_W-1:0] start_row,
    input  logic signed [lppg_pkg::IN_COORD_W-1:0] end_col,
    input  logic signed [lppg_pkg::IN_COORD_W-1:0] end_row,
    input  logic [$clog2(MAX_DIM+1)-1:0]           width_eff,
    input  logic [$clog2(MAX_DIM+1)-1:0]           height_eff,
    output logic [$clog2(MAX_DIM)-1:0]             x0,
    output logic [$clog2(MAX_DIM)-1:0]             y0,
    output logic [$clog2(MAX_DIM)-1:0]             x1,
    output logic [$clog2(MAX_DIM)-1:0]             y1
);
    import lppg_pkg::*;

    localparam int CW  = $clog2(MAX_DIM);
    localparam int EDW = $clog2(MAX_DIM + 1);

    function automatic logic [CW-1:0] clamp_coord(
        input logic signed [IN_COORD_W-1:0] v,
        input logic [EDW-1:0]               dim
    );
        logic signed [CMP_W-1:0] vs;
        logic signed [CMP_W-1:0] ds;
        logic [CW-1:0]           r;
        vs = CMP_W'(v);
        ds = signed'(CMP_W'(dim));
        if (vs < 0)
        begin
            r = '0;
        end
        else if (vs >= ds)
        begin
            r = CW'(ds - CMP_W'(1));
        end
        else
        begin
            r = CW'(vs);
        end
        return r;
    endfunction

    logic [CW-1:0] xa;
    logic [CW-1:0] ya;
    logic [CW-1:0] xb;
    logic [CW-1:0] yb;
    logic          swap;

    always_comb
    begin
        xa   = clamp_coord(start_col, width_eff);
        ya   = clamp_coord(start_row, height_eff);
        xb   = clamp_coord(end_col, width_eff);
        yb   = clamp_coord(end_row, height_eff);
        swap = (xa > xb) || ((xa == xb) && (ya > yb));
        x0   = swap ? xb : xa;
        y0   = swap ? yb : ya;
        x1   = swap ? xa : xb;
        y1   = swap ? ya : yb;
    end

endmodule

// ===== src/lppg_walker.sv =====
// bresenham walk state, one step per request, and the result register
module lppg_walker #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  lppg_pkg::func_t                     req_func,
    input  logic [$clog2(MAX_DIM)-1:0]          req_x0,
    input  logic [$clog2(MAX_DIM)-1:0]          req_y0,
    input  logic [$clog2(MAX_DIM)-1:0]          req_x1,
    input  logic [$clog2(MAX_DIM)-1:0]          req_y1,
    input  logic [$clog2(MAX_DIM+1)-1:0]        width_eff,
    input  logic [$clog2(MAX_DIM+1)-1:0]        height_eff,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lppg_pkg::result_t                   out_item
);
    import lppg_pkg::*;

    localparam int CW  = $clog2(MAX_DIM);
    localparam int EDW = $clog2(MAX_DIM + 1);
    localparam int EW  = CW + 2;
    localparam int RW  = OUT_COORD_W + EDW;
    localparam int PW  = OUT_COORD_W + EDW;

    logic                 line_active_reg;
    logic [CW-1:0]        cur_x_reg;
    logic [CW-1:0]        cur_y_reg;
    logic [CW-1:0]        stop_x_reg;
    logic [CW-1:0]        stop_y_reg;
    logic [CW-1:0]        delta_x_reg;
    logic [CW-1:0]        delta_y_reg;
    logic                 step_x_neg_reg;
    logic                 step_y_neg_reg;
    logic signed [EW-1:0] err_reg;
    logic [INDEX_W-1:0]   count_reg;
    logic                 out_vld_reg;
    result_t              out_reg;

    logic                 take;
    logic                 load_go;
    logic                 step_go;
    logic [CW-1:0]        ld_dx;
    logic [CW-1:0]        ld_dy;
    logic signed [EW-1:0] half_dx;
    logic signed [EW-1:0] half_dy;
    logic signed [EW-1:0] ld_err;
    logic signed [EW-1:0] dx_s;
    logic signed [EW-1:0] dy_s;
    logic                 go_x;
    logic                 go_y;
    logic signed [EW-1:0] err_next;
    logic [CW-1:0]        cur_x_next;
    logic [CW-1:0]        cur_y_next;
    logic [RW-1:0]        row_full;
    logic [OUT_COORD_W-1:0] row;
    logic [OUT_COORD_W-1:0] col;
    logic [PW-1:0]        prod;
    logic                 is_last;
    result_t              item;

    assign req_ready = !out_vld_reg || out_ready;
    assign take      = req_valid && req_ready;
    assign load_go   = take && (req_func == FUNC_LOAD) && (width_eff != '0) && (height_eff != '0);
    assign step_go   = take && (req_func == FUNC_NEXT) && line_active_reg;

    // load: deltas and the halved starting error
    always_comb
    begin
        ld_dx   = req_x1 - req_x0;
        ld_dy   = (req_y1 > req_y0) ? (req_y1 - req_y0) : (req_y0 - req_y1);
        half_dx = signed'(EW'(ld_dx >> 1));
        half_dy = signed'(EW'(ld_dy >> 1));
        ld_err  = (ld_dx > ld_dy) ? half_dx : -half_dy;
    end

    // one step of the walk
    always_comb
    begin
        dx_s       = signed'(EW'(delta_x_reg));
        dy_s       = signed'(EW'(delta_y_reg));
        go_x       = err_reg > -dx_s;
        go_y       = err_reg < dy_s;
        err_next   = err_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (go_x)
        begin
            err_next   = err_next - dy_s;
            cur_x_next = step_x_neg_reg ? (cur_x_reg - CW'(1)) : (cur_x_reg + CW'(1));
        end
        if (go_y)
        begin
            err_next   = err_next + dx_s;
            cur_y_next = step_y_neg_reg ? (cur_y_reg - CW'(1)) : (cur_y_reg + CW'(1));
        end
    end

    // flipped row, address and end mark
    always_comb
    begin
        row_full           = RW'(height_eff) - RW'(cur_y_reg) - RW'(1);
        row                = row_full[OUT_COORD_W-1:0];
        col                = OUT_COORD_W'(cur_x_reg);
        prod               = PW'(row) * PW'(width_eff);
        is_last            = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
        item.sample_index  = count_reg;
        item.point_col     = col;
        item.point_row     = row;
        item.pixel_address = ADDR_W'(prod) + ADDR_W'(col);
        item.last          = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            stop_x_reg      <= '0;
            stop_y_reg      <= '0;
            delta_x_reg     <= '0;
            delta_y_reg     <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            err_reg         <= '0;
            count_reg       <= '0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            out_vld_reg <= step_go || (out_vld_reg && !out_ready);
            if (load_go)
            begin
                cur_x_reg       <= req_x0;
                cur_y_reg       <= req_y0;
                stop_x_reg      <= req_x1;
                stop_y_reg      <= req_y1;
                delta_x_reg     <= ld_dx;
                delta_y_reg     <= ld_dy;
                step_x_neg_reg  <= !(req_x0 < req_x1);
                step_y_neg_reg  <= !(req_y0 < req_y1);
                err_reg         <= ld_err;
                count_reg       <= '0;
                line_active_reg <= 1'b1;
            end
            else if (step_go)
            begin
                count_reg <= count_reg + INDEX_W'(1);
                if (is_last)
                begin
                    line_active_reg <= 1'b0;
                end
                else
                begin
                    cur_x_reg <= cur_x_next;
                    cur_y_reg <= cur_y_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            out_reg <= item;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> cur_x_reg <= stop_x_reg)
        else $error("walk passed the stop column");

    a_y_up_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (line_active_reg && !step_y_neg_reg) |-> cur_y_reg <= stop_y_reg)
        else $error("upward walk passed the stop row");

    a_y_down_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (line_active_reg && step_y_neg_reg) |-> cur_y_reg >= stop_y_reg)
        else $error("downward walk passed the stop row");

    a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(line_active_reg) |-> (out_vld_reg && out_reg.last))
        else $error("line ended without a last point");

endmodule

// ===== src/line_profile_point_generator_top.sv =====
// top level of the line profile point generator
// A load request (tuser 0) takes two endpoints, clamps them into the image set by
// the width and height registers and orders them left to right; it returns nothing
// and is ignored while either dimension is zero. Each next request (tuser 1) then
// returns one point of the Bresenham line with its index, column, flipped row,
// pixel address and a last mark on the end point; a next request with no line gives
// nothing. One request is taken every clock cycle unless m_tready stalls the output;
// a point passes the input register and then the walker's result register, and the
// walker's error update and address multiply are combinational between the two.
module line_profile_point_generator_top #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [lppg_pkg::REG_INDEX_W-1:0]     cfg_index,
    input  logic [lppg_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // start_col, start_row, end_col, end_row
    input  logic [lppg_pkg::S_TDATA_W-1:0]       s_tdata,
    // func
    input  logic [0:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // sample_index, point_col, point_row, pixel_address
    output logic [lppg_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast
);
    import lppg_pkg::*;

    localparam int CW  = $clog2(MAX_DIM);
    localparam int EDW = $clog2(MAX_DIM + 1);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [EDW-1:0]   width_eff;
    logic [EDW-1:0]   height_eff;

    logic [CW-1:0]    prep_x0;
    logic [CW-1:0]    prep_y0;
    logic [CW-1:0]    prep_x1;
    logic [CW-1:0]    prep_y1;

    logic             in_vld_reg;
    logic             in_vld_next;
    func_t            in_func_reg;
    logic [CW-1:0]    in_x0_reg;
    logic [CW-1:0]    in_y0_reg;
    logic [CW-1:0]    in_x1_reg;
    logic [CW-1:0]    in_y1_reg;
    logic             in_load;
    logic             req_ready;
    result_t          out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // dimensions above the supported size act as the supported size
    assign width_eff  = (CMP_W'(width_reg) > CMP_W'(MAX_DIM)) ? EDW'(MAX_DIM) : EDW'(width_reg);
    assign height_eff = (CMP_W'(height_reg) > CMP_W'(MAX_DIM)) ? EDW'(MAX_DIM) : EDW'(height_reg);

    lppg_endpoint_prep #(
        .MAX_DIM (MAX_DIM)
    ) u_prep (
        .start_col  (signed'(s_tdata[IN_COORD_W-1:0])),
        .start_row  (signed'(s_tdata[2*IN_COORD_W-1:IN_COORD_W])),
        .end_col    (signed'(s_tdata[3*IN_COORD_W-1:2*IN_COORD_W])),
        .end_row    (signed'(s_tdata[4*IN_COORD_W-1:3*IN_COORD_W])),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .x0         (prep_x0),
        .y0         (prep_y0),
        .x1         (prep_x1),
        .y1         (prep_y1)
    );

    assign s_tready    = !in_vld_reg || req_ready;
    assign in_load     = s_tvalid && s_tready;
    assign in_vld_next = in_load || (in_vld_reg && !req_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_func_reg <= func_t'(s_tuser[0]);
            in_x0_reg   <= prep_x0;
            in_y0_reg   <= prep_y0;
            in_x1_reg   <= prep_x1;
            in_y1_reg   <= prep_y1;
        end
    end

    lppg_walker #(
        .MAX_DIM (MAX_DIM)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_vld_reg),
        .req_ready  (req_ready),
        .req_func   (in_func_reg),
        .req_x0     (in_x0_reg),
        .req_y0     (in_y0_reg),
        .req_x1     (in_x1_reg),
        .req_y1     (in_y1_reg),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (out_item)
    );

    assign m_tdata = M_TDATA_W'({out_item.pixel_address, out_item.point_row,
                                 out_item.point_col, out_item.sample_index});
    assign m_tlast = out_item.last;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the line profile point generator
module testbench;

    import lppg_pkg::*;

    localparam int MAX_DIM = 1024;
    localparam int COL_LO  = INDEX_W;
    localparam int ROW_LO  = COL_LO + OUT_COORD_W;
    localparam int ADDR_LO = ROW_LO + OUT_COORD_W;

    typedef struct
    {
        func_t                         func;
        logic signed [IN_COORD_W-1:0]  start_col;
        logic signed [IN_COORD_W-1:0]  start_row;
        logic signed [IN_COORD_W-1:0]  end_col;
        logic signed [IN_COORD_W-1:0]  end_row;
    } line_req_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [REG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [DIM_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = FUNC_LOAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    line_req_t pending_requests[$];
    result_t   expected_points[$];
    line_req_t in_flight;
    int        send_gap;
    int        recv_hold;
    int        error_count = 0;
    int        rand_items = 0;
    bit        no_idle = 1'b0;

    // register mirror
    logic [DIM_W-1:0] img_w = '0;
    logic [DIM_W-1:0] img_h = '0;

    // line walk state
    logic [OUT_COORD_W-1:0] pos_col = '0;
    logic [OUT_COORD_W-1:0] pos_row = '0;
    logic [OUT_COORD_W-1:0] goal_col = '0;
    logic [OUT_COORD_W-1:0] goal_row = '0;
    logic [OUT_COORD_W-1:0] span_col = '0;
    logic [OUT_COORD_W-1:0] span_row = '0;
    bit                     col_down = 1'b0;
    bit                     row_down = 1'b0;
    logic signed [11:0]     bres_err = '0;
    logic [10:0]            point_idx = '0;
    bit                     walking = 1'b0;

    line_profile_point_generator_top #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int effective_dim(logic [DIM_W-1:0] dim);
        return (dim > MAX_DIM) ? MAX_DIM : int'(dim);
    endfunction

    function automatic int clamp_to_dim(int v, int dim);
        if (v < 0)
            return 0;
        if (v >= dim)
            return dim - 1;
        return v;
    endfunction

    // walks one accepted request through the line state
    task automatic apply_request(input line_req_t r);
        int      w;
        int      h;
        int      x0;
        int      y0;
        int      x1;
        int      y1;
        int      t;
        int      dx;
        int      dy;
        int      e2;
        int      err;
        int      row;
        result_t pt;
        w = effective_dim(img_w);
        h = effective_dim(img_h);
        if (r.func == FUNC_LOAD)
        begin
            if (w == 0 || h == 0)
                return;
            x0 = clamp_to_dim(int'(r.start_col), w);
            y0 = clamp_to_dim(int'(r.start_row), h);
            x1 = clamp_to_dim(int'(r.end_col), w);
            y1 = clamp_to_dim(int'(r.end_row), h);
            if (x0 > x1 || (x0 == x1 && y0 > y1))
            begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            pos_col   = x0[OUT_COORD_W-1:0];
            pos_row   = y0[OUT_COORD_W-1:0];
            goal_col  = x1[OUT_COORD_W-1:0];
            goal_row  = y1[OUT_COORD_W-1:0];
            span_col  = dx[OUT_COORD_W-1:0];
            span_row  = dy[OUT_COORD_W-1:0];
            col_down  = !(x0 < x1);
            row_down  = !(y0 < y1);
            err       = ((dx > dy) ? dx : -dy) / 2;
            bres_err  = err[11:0];
            point_idx = '0;
            walking   = 1'b1;
            return;
        end
        if (!walking)
            return;
        row = (h - 1 - int'(pos_row)) & 32'h3FF;
        pt.sample_index  = point_idx[INDEX_W-1:0];
        pt.point_col     = pos_col;
        pt.point_row     = row[OUT_COORD_W-1:0];
        pt.pixel_address = ADDR_W'(row * w + int'(pos_col));
        pt.last          = (pos_col == goal_col && pos_row == goal_row);
        expected_points.insert(expected_points.size(), pt);
        point_idx = point_idx + 1'b1;
        if (pt.last)
            walking = 1'b0;
        else
        begin
            e2  = int'(bres_err);
            err = e2;
            if (e2 > -int'(span_col))
            begin
                err = err - int'(span_row);
                pos_col = col_down ? pos_col - 1'b1 : pos_col + 1'b1;
            end
            if (e2 < int'(span_row))
            begin
                err = err + int'(span_col);
                pos_row = row_down ? pos_row - 1'b1 : pos_row + 1'b1;
            end
            bres_err = err[11:0];
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_point();
        result_t want;
        if (expected_points.size() == 0)
        begin
            $error("point with nothing expected: tdata %h last %b", m_tdata, m_tlast);
            error_count++;
            return;
        end
        want = expected_points.pop_front();
        check_field("sample_index", want.sample_index, m_tdata[COL_LO-1:0]);
        check_field("point_col", want.point_col, m_tdata[ROW_LO-1:COL_LO]);
        check_field("point_row", want.point_row, m_tdata[ADDR_LO-1:ROW_LO]);
        check_field("pixel_address", want.pixel_address,
                    m_tdata[ADDR_LO+ADDR_W-1:ADDR_LO]);
        check_field("last", want.last, m_tlast);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= FUNC_LOAD;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_request(in_flight);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    in_flight = pending_requests.pop_front();
                    s_tdata  <= {4'b0, in_flight.end_row, in_flight.end_col,
                                 in_flight.start_row, in_flight.start_col};
                    s_tuser  <= in_flight.func;
                    s_tvalid <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 7);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // point monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_point();
                recv_hold = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic line_req_t make_load(int sc, int sr, int ec, int er);
        line_req_t r;
        r.func      = FUNC_LOAD;
        r.start_col = IN_COORD_W'(sc);
        r.start_row = IN_COORD_W'(sr);
        r.end_col   = IN_COORD_W'(ec);
        r.end_row   = IN_COORD_W'(er);
        return r;
    endfunction

    function automatic int line_points(line_req_t r);
        int w;
        int h;
        int dx;
        int dy;
        w = effective_dim(img_w);
        h = effective_dim(img_h);
        if (w == 0 || h == 0)
            return 0;
        dx = clamp_to_dim(int'(r.end_col), w) - clamp_to_dim(int'(r.start_col), w);
        dy = clamp_to_dim(int'(r.end_row), h) - clamp_to_dim(int'(r.start_row), h);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 11))
            0:       return 1;
            1:       return 2;
            2:       return 1024;
            3:       return 2047;
            4:       return $urandom_range(1025, 2046);
            5:       return $urandom_range(41, 1023);
            default: return $urandom_range(3, 40);
        endcase
    endfunction

    task automatic push_load(input int sc, input int sr, input int ec, input int er);
        pending_requests.insert(pending_requests.size(), make_load(sc, sr, ec, er));
    endtask

    // next requests carry junk coordinates, which the block must ignore
    task automatic push_next(input int n);
        line_req_t r;
        repeat (n)
        begin
            r.func      = FUNC_NEXT;
            r.start_col = IN_COORD_W'($urandom);
            r.start_row = IN_COORD_W'($urandom);
            r.end_col   = IN_COORD_W'($urandom);
            r.end_row   = IN_COORD_W'($urandom);
            pending_requests.insert(pending_requests.size(), r);
        end
    endtask

    // sampled away from the active edge so the driver and monitor have settled
    task automatic wait_idle();
        while (pending_requests.size() != 0 || s_tvalid || expected_points.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_dims(input int w, input int h);
        wait_idle();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= DIM_W'(w);
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= DIM_W'(h);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        img_w = DIM_W'(w);
        img_h = DIM_W'(h);
    endtask

    // one load with a walk of it, full, partial or overrun
    task automatic add_walk(input bit noisy);
        int        ew;
        int        eh;
        int        sc;
        int        sr;
        int        pts;
        int        nexts;
        line_req_t r;
        ew = effective_dim(img_w);
        eh = effective_dim(img_h);
        if (noisy)
            r = make_load($urandom, $urandom, $urandom, $urandom);
        else
        begin
            sc = int'($urandom_range(0, ew + 3)) - 2;
            sr = int'($urandom_range(0, eh + 3)) - 2;
            r = make_load(sc, sr, sc + int'($urandom_range(0, 24)) - 12,
                          sr + int'($urandom_range(0, 24)) - 12);
        end
        pts = line_points(r);
        case ($urandom_range(0, 9))
            0, 1:    nexts = $urandom_range(0, pts);
            2:       nexts = pts + $urandom_range(1, 3);
            default: nexts = pts;
        endcase
        if (noisy && nexts > 40)
            nexts = $urandom_range(0, 40);
        pending_requests.insert(pending_requests.size(), r);
        push_next(nexts);
        if (pts != 0)
            rand_items += 1 + ((nexts < pts) ? nexts : pts);
    endtask

    initial
    begin
        int w;
        int h;
        int choice;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no image yet: nothing is produced
        push_next(1);
        push_load(-4096, -4096, 4095, 4095);
        push_next(1);

        set_dims(8, 6);
        push_load(-4096, 4095, 4095, -4096);
        push_next(4);
        // reload mid walk, vertical line that needs the swap
        push_load(3, 5, 3, 1);
        push_next(6);
        push_load(5, 2, 5, 2);
        push_next(2);
        // steep line, negative initial error from an odd dy
        push_load(1, 0, 2, 5);
        push_next(3);

        // zero width: load ignored, walk goes on
        set_dims(0, 6);
        push_load(0, 0, 7, 5);
        push_next(2);

        // shorter image under an active line: flipped row wraps
        set_dims(8, 3);
        push_next(2);

        // far corner of the largest image, oversized dimensions clamp to it
        set_dims(2047, 2047);
        push_load(1018, 1018, 4095, 4095);
        push_next(6);
        set_dims(1024, 1);
        push_load(4095, 0, 1016, 0);
        push_next(8);

        while (rand_items < 800)
        begin
            w = pick_dim();
            h = pick_dim();
            if ($urandom_range(0, 11) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    w = 0;
                else
                    h = 0;
            end
            set_dims(w, h);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 12))
            begin
                choice = $urandom_range(0, 19);
                if (choice < 14)
                    add_walk(1'b0);
                else if (choice < 17)
                    add_walk(1'b1);
                else
                    push_next($urandom_range(1, 3));
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
